>>> rtl/core/jmc_pkg.sv
`default_nettype none
package jmc_pkg;

  localparam logic [4:0] ST_ROOT      = 5'd0;
  localparam logic [4:0] ST_OBJ_OPEN  = 5'd1;
  localparam logic [4:0] ST_KEY_REQ   = 5'd2;
  localparam logic [4:0] ST_KEY       = 5'd3;
  localparam logic [4:0] ST_COLON     = 5'd4;
  localparam logic [4:0] ST_VALUE     = 5'd5;
  localparam logic [4:0] ST_ARR_OPEN  = 5'd6;
  localparam logic [4:0] ST_STR       = 5'd7;
  localparam logic [4:0] ST_NUM_MINUS = 5'd8;
  localparam logic [4:0] ST_NUM_ZERO  = 5'd9;
  localparam logic [4:0] ST_NUM_INT   = 5'd10;
  localparam logic [4:0] ST_NUM_DOT   = 5'd11;
  localparam logic [4:0] ST_NUM_FRAC  = 5'd12;
  localparam logic [4:0] ST_NUM_E     = 5'd13;
  localparam logic [4:0] ST_NUM_ESIGN = 5'd14;
  localparam logic [4:0] ST_NUM_EXP   = 5'd15;
  localparam logic [4:0] ST_LIT       = 5'd16;
  localparam logic [4:0] ST_AFTER     = 5'd17;
  localparam logic [4:0] ST_DONE      = 5'd18;

  localparam int KEY_COUNT = 9;
  localparam int KEY_CMD_BIT = 7;
  localparam int KEY_PROMPT_BIT = 8;
  localparam logic [8:0] KEY_ALL = 9'h1FF;
  localparam logic [6:0] HEARTBEAT_ALL = 7'h7F;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last;
  } beat_t;

  function automatic logic [7:0] key_char(input logic [3:0] k, input logic [3:0] p);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      4'd0: c = (p == 4'd0) ? "t" : (p == 4'd1) ? "o" : (p == 4'd2) ? "t" :
                (p == 4'd3) ? "a" : (p == 4'd4) ? "l" : 8'h00;
      4'd1: c = (p == 4'd0) ? "r" : (p == 4'd1) ? "u" : (p == 4'd2) ? "n" :
                (p == 4'd3) ? "n" : (p == 4'd4) ? "i" : (p == 4'd5) ? "n" :
                (p == 4'd6) ? "g" : 8'h00;
      4'd2: c = (p == 4'd0) ? "w" : (p == 4'd1) ? "a" : (p == 4'd2) ? "i" :
                (p == 4'd3) ? "t" : (p == 4'd4) ? "i" : (p == 4'd5) ? "n" :
                (p == 4'd6) ? "g" : 8'h00;
      4'd3: c = (p == 4'd0) ? "m" : (p == 4'd1) ? "s" : (p == 4'd2) ? "g" : 8'h00;
      4'd4: c = (p == 4'd0) ? "e" : (p == 4'd1) ? "n" : (p == 4'd2) ? "t" :
                (p == 4'd3) ? "r" : (p == 4'd4) ? "i" : (p == 4'd5) ? "e" :
                (p == 4'd6) ? "s" : 8'h00;
      4'd5: c = (p == 4'd0) ? "t" : (p == 4'd1) ? "o" : (p == 4'd2) ? "k" :
                (p == 4'd3) ? "e" : (p == 4'd4) ? "n" : (p == 4'd5) ? "s" : 8'h00;
      4'd6: c = (p == 4'd0) ? "t" : (p == 4'd1) ? "o" : (p == 4'd2) ? "k" :
                (p == 4'd3) ? "e" : (p == 4'd4) ? "n" : (p == 4'd5) ? "s" :
                (p == 4'd6) ? "_" : (p == 4'd7) ? "t" : (p == 4'd8) ? "o" :
                (p == 4'd9) ? "d" : (p == 4'd10) ? "a" : (p == 4'd11) ? "y" : 8'h00;
      4'd7: c = (p == 4'd0) ? "c" : (p == 4'd1) ? "m" : (p == 4'd2) ? "d" : 8'h00;
      4'd8: c = (p == 4'd0) ? "p" : (p == 4'd1) ? "r" : (p == 4'd2) ? "o" :
                (p == 4'd3) ? "m" : (p == 4'd4) ? "p" : (p == 4'd5) ? "t" : 8'h00;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] key_len(input logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0: l = 4'd5;
      4'd1: l = 4'd7;
      4'd2: l = 4'd7;
      4'd3: l = 4'd3;
      4'd4: l = 4'd7;
      4'd5: l = 4'd6;
      4'd6: l = 4'd12;
      4'd7: l = 4'd3;
      4'd8: l = 4'd6;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      2'd0: c = (p == 3'd1) ? "r" : (p == 3'd2) ? "u" : (p == 3'd3) ? "e" : 8'h00;
      2'd1: c = (p == 3'd1) ? "a" : (p == 3'd2) ? "l" : (p == 3'd3) ? "s" :
                (p == 3'd4) ? "e" : 8'h00;
      2'd2: c = (p == 3'd1) ? "u" : (p == 3'd2) ? "l" : (p == 3'd3) ? "l" : 8'h00;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/jmc_input_stage.sv
`default_nettype none
module jmc_input_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire jmc_pkg::beat_t in_beat,
  input  wire logic          core_stall,
  output logic               beat_valid,
  output jmc_pkg::beat_t     beat
);
  import jmc_pkg::*;

  assign in_stall = beat_valid && core_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      beat <= in_beat;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/jmc_parser.sv
`default_nettype none
module jmc_parser #(
  parameter int MAX_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           beat_valid,
  input  wire jmc_pkg::beat_t beat,
  output logic                core_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_class
);
  import jmc_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [4:0] gstate, gstate_next;
  logic [MAX_DEPTH-1:0] stack, stack_next;
  logic [DW-1:0] depth, depth_next;
  logic [1:0] upend, upend_next;
  logic [2:0] urange, urange_next;
  logic [8:0] cand, cand_next;
  logic [3:0] kpos, kpos_next;
  logic [2:0] lpos, lpos_next;
  logic [1:0] lkind, lkind_next;
  logic [6:0] hb, hb_next;
  logic prompt, prompt_next, cmd, cmd_next, failed, failed_next, vcmd, vcmd_next;

  logic take, fire;
  assign core_stall = out_valid && out_stall;
  assign take = beat_valid && !core_stall;
  assign fire = take && beat.last;

  always_comb begin
    logic [7:0] b;
    logic sp, dg, kind, nfail, ex, do_open, do_close, do_after, do_val, skey;
    logic [1:0] sr;
    logic [7:0] lo, hi;
    logic [8:0] matched;
    logic okind;
    b = beat.data_byte;
    sp = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    dg = (b >= 8'h30) && (b <= 8'h39);
    ex = (b == 8'h65) || (b == 8'h45);
    kind = (depth == '0) ? 1'b0 : stack[IW'(depth - DW'(1))];
    gstate_next = gstate; stack_next = stack; depth_next = depth;
    upend_next = upend; urange_next = urange; cand_next = cand; kpos_next = kpos;
    lpos_next = lpos; lkind_next = lkind; hb_next = hb; prompt_next = prompt;
    cmd_next = cmd; failed_next = failed; vcmd_next = vcmd;
    nfail = 1'b0; do_open = 1'b0; okind = 1'b0; do_close = 1'b0;
    do_after = 1'b0; do_val = 1'b0; skey = 1'b0;
    sr = 2'd0; lo = 8'h80; hi = 8'hBF; matched = '0;
    if (beat.has_byte && !failed) begin
      if (gstate == ST_KEY || gstate == ST_STR) begin
        if (upend != 2'd0) begin
          if (urange == 3'd1) lo = 8'hA0;
          else if (urange == 3'd2) hi = 8'h9F;
          else if (urange == 3'd3) lo = 8'h90;
          else if (urange == 3'd4) hi = 8'h8F;
          if (b < lo || b > hi) sr = 2'd2;
          else begin
            urange_next = 3'd0;
            upend_next = upend - 2'd1;
          end
        end else if (b == 8'h22) sr = 2'd1;
        else if (b == 8'h5C || b < 8'h20) sr = 2'd2;
        else if (b < 8'h80) sr = 2'd0;
        else if (b >= 8'hC2 && b <= 8'hDF) upend_next = 2'd1;
        else if (b == 8'hE0) begin upend_next = 2'd2; urange_next = 3'd1; end
        else if (b == 8'hED) begin upend_next = 2'd2; urange_next = 3'd2; end
        else if (b >= 8'hE1 && b <= 8'hEF) upend_next = 2'd2;
        else if (b == 8'hF0) begin upend_next = 2'd3; urange_next = 3'd3; end
        else if (b >= 8'hF1 && b <= 8'hF3) upend_next = 2'd3;
        else if (b == 8'hF4) begin upend_next = 2'd3; urange_next = 3'd4; end
        else sr = 2'd2;
      end
      unique case (gstate)
        ST_ROOT: begin
          if (b == 8'h7B) do_open = 1'b1;
          else if (!sp) nfail = 1'b1;
        end
        ST_OBJ_OPEN: begin
          if (b == 8'h7D) do_close = 1'b1;
          else if (b == 8'h22) skey = 1'b1;
          else if (!sp) nfail = 1'b1;
        end
        ST_KEY_REQ: begin
          if (b == 8'h22) skey = 1'b1;
          else if (!sp) nfail = 1'b1;
        end
        ST_KEY: begin
          if (sr == 2'd2) nfail = 1'b1;
          else if (sr == 2'd1) begin
            for (int i = 0; i < KEY_COUNT; i++)
              matched[i] = cand[i] && (key_len(4'(i)) == kpos);
            if (matched[KEY_CMD_BIT]) begin cmd_next = 1'b1; vcmd_next = 1'b1; end
            if (depth == DW'(1)) begin
              hb_next = hb | matched[6:0];
              if (matched[KEY_PROMPT_BIT]) prompt_next = 1'b1;
            end
            gstate_next = ST_COLON;
          end else begin
            for (int i = 0; i < KEY_COUNT; i++)
              if (kpos >= key_len(4'(i)) || key_char(4'(i), kpos) != b)
                cand_next[i] = 1'b0;
            if (kpos < 4'd15) kpos_next = kpos + 4'd1;
          end
        end
        ST_COLON: begin
          if (b == 8'h3A) gstate_next = ST_VALUE;
          else if (!sp) nfail = 1'b1;
        end
        ST_VALUE: begin
          if (!sp) do_val = 1'b1;
        end
        ST_ARR_OPEN: begin
          if (b == 8'h5D) do_close = 1'b1;
          else if (!sp) do_val = 1'b1;
        end
        ST_STR: begin
          if (sr == 2'd2) nfail = 1'b1;
          else if (sr == 2'd1) gstate_next = ST_AFTER;
        end
        ST_LIT: begin
          if (lkind > 2'd2 || lpos >= lit_len(lkind) || lit_char(lkind, lpos) != b)
            nfail = 1'b1;
          else begin
            lpos_next = lpos + 3'd1;
            if (lpos + 3'd1 == lit_len(lkind)) gstate_next = ST_AFTER;
          end
        end
        ST_AFTER: do_after = 1'b1;
        ST_DONE: begin
          if (!sp) nfail = 1'b1;
        end
        ST_NUM_MINUS: begin
          if (b == 8'h30) gstate_next = ST_NUM_ZERO;
          else if (dg) gstate_next = ST_NUM_INT;
          else nfail = 1'b1;
        end
        ST_NUM_DOT: begin
          if (dg) gstate_next = ST_NUM_FRAC; else nfail = 1'b1;
        end
        ST_NUM_E: begin
          if (b == 8'h2B || b == 8'h2D) gstate_next = ST_NUM_ESIGN;
          else if (dg) gstate_next = ST_NUM_EXP;
          else nfail = 1'b1;
        end
        ST_NUM_ESIGN: begin
          if (dg) gstate_next = ST_NUM_EXP; else nfail = 1'b1;
        end
        ST_NUM_ZERO, ST_NUM_INT, ST_NUM_FRAC, ST_NUM_EXP: begin
          if (dg && gstate != ST_NUM_ZERO) gstate_next = gstate;
          else if (b == 8'h2E && (gstate == ST_NUM_ZERO || gstate == ST_NUM_INT))
            gstate_next = ST_NUM_DOT;
          else if (ex && gstate != ST_NUM_EXP) gstate_next = ST_NUM_E;
          else begin
            gstate_next = ST_AFTER;
            do_after = 1'b1;
          end
        end
        default: nfail = 1'b1;
      endcase
      if (skey) begin
        cand_next = KEY_ALL; kpos_next = 4'd0; upend_next = 2'd0;
        urange_next = 3'd0; gstate_next = ST_KEY;
      end
      if (do_val) begin
        vcmd_next = 1'b0;
        if (vcmd && b != 8'h22) nfail = 1'b1;
        else if (b == 8'h7B) do_open = 1'b1;
        else if (b == 8'h5B) begin do_open = 1'b1; okind = 1'b1; end
        else if (b == 8'h22) begin
          upend_next = 2'd0; urange_next = 3'd0; gstate_next = ST_STR;
        end else if (b == 8'h74 || b == 8'h66 || b == 8'h6E) begin
          lkind_next = (b == 8'h74) ? 2'd0 : (b == 8'h66) ? 2'd1 : 2'd2;
          lpos_next = 3'd1;
          gstate_next = ST_LIT;
        end else if (b == 8'h2D) gstate_next = ST_NUM_MINUS;
        else if (b == 8'h30) gstate_next = ST_NUM_ZERO;
        else if (dg) gstate_next = ST_NUM_INT;
        else nfail = 1'b1;
      end
      if (do_after && !sp) begin
        if (b == 8'h2C) gstate_next = kind ? ST_VALUE : ST_KEY_REQ;
        else if ((b == 8'h7D && !kind) || (b == 8'h5D && kind)) do_close = 1'b1;
        else nfail = 1'b1;
      end
      if (do_open) begin
        if (depth >= DW'(MAX_DEPTH)) nfail = 1'b1;
        else begin
          stack_next[IW'(depth)] = okind;
          depth_next = depth + DW'(1);
          gstate_next = okind ? ST_ARR_OPEN : ST_OBJ_OPEN;
        end
      end
      if (do_close) begin
        depth_next = (depth != '0) ? depth - DW'(1) : depth;
        gstate_next = (depth_next == '0) ? ST_DONE : ST_AFTER;
      end
      if (nfail) failed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || fire) begin
      gstate <= ST_ROOT; stack <= '0; depth <= '0; upend <= 2'd0; urange <= 3'd0;
      cand <= KEY_ALL; kpos <= 4'd0; lpos <= 3'd0; lkind <= 2'd0; hb <= 7'd0;
      prompt <= 1'b0; cmd <= 1'b0; failed <= 1'b0; vcmd <= 1'b0;
    end else if (take) begin
      gstate <= gstate_next; stack <= stack_next; depth <= depth_next;
      upend <= upend_next; urange <= urange_next; cand <= cand_next;
      kpos <= kpos_next; lpos <= lpos_next; lkind <= lkind_next; hb <= hb_next;
      prompt <= prompt_next; cmd <= cmd_next; failed <= failed_next;
      vcmd <= vcmd_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!core_stall) begin
      out_valid <= fire;
    end
    if (fire) begin
      out_class <= !(!failed_next && gstate_next == ST_DONE && !cmd_next &&
                     hb_next == HEARTBEAT_ALL && !prompt_next);
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/json_message_classifier.sv
`default_nettype none
// channel | signals                                | beat
// in      | in_valid, in_stall, has_byte, data_byte, last | one byte or end marker
// out     | out_valid, out_stall, message_class    | one class per message
// One beat accepted per cycle unless the result is stalled; class is registered.
// Input register and result register each advance unless the result is stalled.
// rst is synchronous and returns the parser to expect-root-object.
module json_message_classifier #(
  parameter int MAX_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       has_byte,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            message_class
);
  import jmc_pkg::*;

  beat_t in_beat, beat;
  logic beat_valid, core_stall;

  assign in_beat = '{has_byte: has_byte, data_byte: data_byte, last: last};

  jmc_input_stage u_in (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_beat(in_beat), .core_stall(core_stall), .beat_valid(beat_valid), .beat(beat)
  );

  jmc_parser #(.MAX_DEPTH(MAX_DEPTH)) u_parse (
    .clk(clk), .rst(rst), .beat_valid(beat_valid), .beat(beat),
    .core_stall(core_stall), .out_valid(out_valid), .out_stall(out_stall),
    .out_class(message_class)
  );
endmodule
`default_nettype wire
